>>> hdl/heap_allocation_checker_assert.svh
// Assertion macros for the heap allocation checker.
// Used by the top level; no other dependencies.
`ifndef HEAP_ALLOCATION_CHECKER_ASSERT_SVH
`define HEAP_ALLOCATION_CHECKER_ASSERT_SVH
`ifndef SYNTHESIS
`define HAC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define HAC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define HAC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define HAC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

>>> hdl/hac_pkg.sv
// Shared types and constants of the heap allocation checker.
// No dependencies.
package hac_pkg;
  localparam int TableEntriesDef = 64;
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_ALLOC = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  typedef enum logic [2:0] {
    OP_ALLOC_ENTRY = 3'd0, OP_ALLOC_RET = 3'd1, OP_FREE = 3'd2,
    OP_CALL = 3'd3, OP_SCAN = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    RS_OK = 3'd0, RS_UAF = 3'd1, RS_DOUBLE = 3'd2, RS_INVALID = 3'd3,
    RS_FULL = 3'd4, RS_LEAK = 3'd5, RS_NOLEAK = 3'd6, RS_HALTED = 3'd7
  } rstat_t;

  // Controller to datapath.
  typedef struct packed {
    logic latch_in;    // capture the input beat
    logic clr_walk;    // restart the table walk
    logic adv_walk;    // step to the next entry
    logic set_pend;    // latch pending size
    logic write_ent;   // write the chosen entry
    logic free_ent;    // mark the chosen entry freed
    logic mark_rep;    // set reported bit of current entry
    logic set_halt;
    logic load_out;    // load output register
    logic set_last;    // flag the held beat as the last one
    rstat_t out_st;
    logic out_last;
    logic out_zero;    // zero the address field
    logic out_leak;    // take address and size from the table
  } hac_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    op_t op;
    logic known_op;
    logic halted;
    logic walk_done;   // current index is the last entry
    logic found;       // address match seen
    logic found_alloc; // matched entry is allocated
    logic have_slot;   // empty or freed entry available
    logic cur_leak;    // current entry is an unreported allocated block
  } hac_stat_t;
endpackage

>>> hdl/heap_allocation_checker.sv
// Top level of the heap allocation checker.
// Depends on hac_pkg, hac_ctrl, hac_datapath and the assertion header.
//
// Input channel: in_operation / in_argument, one beat per heap event.
// Output channel: out_status, out_report_address, out_report_size, out_last.
// Alloc entry and halted beats are loaded from the decode state; the controller
// then returns to idle for the next event. Unknown codes give no beat.
// Alloc return, free and call walk the address RAM one entry per cycle (one
// read port): table_full, faults and calls load the beat at the walk end,
// and a table write or free loads it from a done state after the walk;
// the next event can be taken in the cycle the beat rises.
// A leak scan with L leaked blocks gives L leak beats, or one no_leak beat,
// and pauses while the output is stalled; each leak beat is held until the
// next leak or the walk end sets its last.
// The input is stalled while an event is in work; a result waits in the
// output register, decode waits while it is stalled, and the scan pauses.
// Reset clears the status table, reported bits, pending size and halt flag;
// address and size RAMs need no clearing. After a fatal error every event
// yields one halted beat.
module heap_allocation_checker import hac_pkg::*; #(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_argument,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [63:0] out_report_address,
  output logic [63:0] out_report_size,
  output logic        out_last
);
  `include "heap_allocation_checker_assert.svh"
  hac_cmd_t  cmd;
  hac_stat_t stat;

  hac_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd));

  hac_datapath #(.TableEntries(TableEntries)) u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd),
    .stat(stat), .in_operation(in_operation), .in_argument(in_argument),
    .out_status(out_status), .out_report_address(out_report_address),
    .out_report_size(out_report_size), .out_last(out_last));

  `HAC_ASSERT_NEVER(a_no_overwrite, clk, rst_n, cmd.load_out && out_valid && out_stall, "result overwritten")
  `HAC_ASSERT_NEVER(a_one_write, clk, rst_n, cmd.write_ent && cmd.free_ent, "write and free together")
  `HAC_ASSERT_IMPL(a_halt_sticky, clk, rst_n, stat.halted |=> stat.halted, "halt dropped")
endmodule

>>> hdl/hac_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module hac_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write, and read registered (a write returns the old data)
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> hdl/hac_datapath.sv
// Datapath: entry tables, walk index, match search and output register.
// Depends on hac_pkg and hac_ram.
module hac_datapath import hac_pkg::*; #(
  parameter int TableEntries = TableEntriesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  hac_cmd_t    cmd,
  output hac_stat_t   stat,
  input  logic [2:0]  in_operation,
  input  logic [63:0] in_argument,
  output logic [2:0]  out_status,
  output logic [63:0] out_report_address,
  output logic [63:0] out_report_size,
  output logic        out_last
);
  localparam int IW = $clog2(TableEntries);
  localparam logic [IW-1:0] LastIdx = IW'(TableEntries - 1);

  logic [2:0]  op_r;
  logic [63:0] arg_r, pend_r;
  logic        halt_r;
  logic [IW-1:0] idx_r, idx_nxt, hit_r, slot_r;
  logic found_r, empty_r, freed_r;
  logic [1:0] status_r [TableEntries];
  logic [TableEntries-1:0] rep_r;
  logic [IW-1:0] raddr, waddr;
  logic [63:0] addr_q, size_q;
  logic [IW-1:0] rd_idx_r;
  logic rd_ok_r;
  logic [IW-1:0] ram_a;
  logic match;

  // Walk index; the RAM is addressed with the next index, so its data matches rd_idx_r
  assign idx_nxt = cmd.clr_walk ? '0 : (cmd.adv_walk ? idx_r + 1'b1 : idx_r);
  assign raddr = idx_nxt;
  assign waddr = found_r ? hit_r : slot_r;
  assign ram_a = cmd.write_ent ? waddr : raddr;

  hac_ram #(.Width(64), .Depth(TableEntries)) u_addr (
    .clk(clk), .we(cmd.write_ent), .addr(ram_a), .wdata(arg_r), .rdata(addr_q));
  hac_ram #(.Width(64), .Depth(TableEntries)) u_size (
    .clk(clk), .we(cmd.write_ent), .addr(ram_a), .wdata(pend_r), .rdata(size_q));

  assign match = rd_ok_r
                 && (status_r[rd_idx_r] == ST_ALLOC || status_r[rd_idx_r] == ST_FREED)
                 && addr_q == arg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halt_r <= 1'b0; pend_r <= '0; rep_r <= '0; idx_r <= '0; rd_ok_r <= 1'b0;
      found_r <= 1'b0; empty_r <= 1'b0; freed_r <= 1'b0;
      for (int i = 0; i < TableEntries; i++) status_r[i] <= ST_EMPTY;
    end else begin
      idx_r <= idx_nxt;
      rd_idx_r <= idx_nxt;
      // Keep the read valid while the walk holds on an entry
      rd_ok_r <= (cmd.adv_walk || cmd.clr_walk || rd_ok_r) && !cmd.write_ent;
      if (cmd.latch_in) begin
        op_r <= in_operation; arg_r <= in_argument;
      end
      if (cmd.clr_walk) begin
        found_r <= 1'b0; empty_r <= 1'b0; freed_r <= 1'b0;
      end else if (rd_ok_r) begin
        // Keep lowest match, lowest empty, lowest freed
        if (match && !found_r) begin found_r <= 1'b1; hit_r <= rd_idx_r; end
        if (status_r[rd_idx_r] == ST_EMPTY && !empty_r) begin
          empty_r <= 1'b1; slot_r <= rd_idx_r;
        end else if (status_r[rd_idx_r] == ST_FREED && !empty_r && !freed_r) begin
          freed_r <= 1'b1; slot_r <= rd_idx_r;
        end
      end
      if (cmd.set_pend) pend_r <= arg_r;
      if (cmd.set_halt) halt_r <= 1'b1;
      if (cmd.write_ent) begin
        status_r[waddr] <= ST_ALLOC; rep_r[waddr] <= 1'b0;
      end
      if (cmd.free_ent) status_r[hit_r] <= ST_FREED;
      if (cmd.mark_rep) rep_r[rd_idx_r] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status <= cmd.out_st;
      out_last <= cmd.out_last;
      out_report_address <= cmd.out_zero ? '0 : (cmd.out_leak ? addr_q : arg_r);
      out_report_size <= cmd.out_leak ? size_q : '0;
    end else if (cmd.set_last) begin
      out_last <= 1'b1;
    end
  end

  assign stat.op = op_t'(op_r);
  assign stat.known_op = (op_r <= 3'd4);
  assign stat.halted = halt_r;
  assign stat.walk_done = rd_ok_r && (rd_idx_r == LastIdx);
  assign stat.found = found_r || match;
  assign stat.found_alloc = found_r ? (status_r[hit_r] == ST_ALLOC)
                                    : (status_r[rd_idx_r] == ST_ALLOC);
  assign stat.have_slot = empty_r || freed_r || (rd_ok_r &&
      (status_r[rd_idx_r] == ST_EMPTY || status_r[rd_idx_r] == ST_FREED));
  assign stat.cur_leak = rd_ok_r && status_r[rd_idx_r] == ST_ALLOC && !rep_r[rd_idx_r];
endmodule

>>> hdl/hac_ctrl.sv
// Controller: sequences lookups, writes, leak scan and result beats.
// Depends on hac_pkg.
module hac_ctrl import hac_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  hac_stat_t stat,
  output hac_cmd_t  cmd
);
  typedef enum logic [2:0] {S_IDLE, S_DECODE, S_WALK, S_DONE, S_SCAN} state_t;
  state_t state_r, state_nxt;
  logic ov_r, ov_nxt;
  logic pend_leak_r, pend_leak_nxt; // a leak beat is held, waiting for its last flag

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r; ov_nxt = ov_r && out_stall;
    pend_leak_nxt = pend_leak_r;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.latch_in = 1'b1; state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (!ov_nxt) begin
          if (stat.halted) begin
            cmd.load_out = 1'b1; cmd.out_st = RS_HALTED; cmd.out_zero = 1'b1;
            ov_nxt = 1'b1; state_nxt = S_IDLE;
          end else if (!stat.known_op) state_nxt = S_IDLE;
          else if (stat.op == OP_ALLOC_ENTRY) begin
            cmd.set_pend = 1'b1; cmd.load_out = 1'b1; cmd.out_st = RS_OK;
            cmd.out_zero = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
          end else begin
            cmd.clr_walk = 1'b1; pend_leak_nxt = 1'b0;
            state_nxt = (stat.op == OP_SCAN) ? S_SCAN : S_WALK;
          end
        end
      end
      S_WALK: begin
        if (stat.walk_done) state_nxt = S_DONE;
        else cmd.adv_walk = 1'b1;
        if (stat.walk_done) begin
          // final decision using last entry included in stat
          state_nxt = S_IDLE; cmd.load_out = 1'b1; ov_nxt = 1'b1;
          case (stat.op)
            OP_ALLOC_RET: begin
              if (stat.found || stat.have_slot) begin
                cmd.out_st = RS_OK; state_nxt = S_DONE; cmd.load_out = 1'b0;
                ov_nxt = ov_r && out_stall;
              end else cmd.out_st = RS_FULL;
            end
            OP_FREE: begin
              if (stat.found && stat.found_alloc) begin
                cmd.out_st = RS_OK; cmd.free_ent = 1'b0; state_nxt = S_DONE;
                cmd.load_out = 1'b0; ov_nxt = ov_r && out_stall;
              end else if (stat.found) begin
                cmd.out_st = RS_DOUBLE; cmd.set_halt = 1'b1;
              end else begin
                cmd.out_st = RS_INVALID; cmd.set_halt = 1'b1;
              end
            end
            default: begin
              if (stat.found && !stat.found_alloc) begin
                cmd.out_st = RS_UAF; cmd.set_halt = 1'b1;
              end else cmd.out_st = RS_OK;
            end
          endcase
        end
      end
      S_DONE: begin
        // match and slot registers are settled now
        cmd.load_out = 1'b1; cmd.out_st = RS_OK; ov_nxt = 1'b1;
        if (stat.op == OP_FREE) cmd.free_ent = 1'b1;
        else cmd.write_ent = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (stat.cur_leak && pend_leak_r) begin
          // release the held beat; stay on this entry
          ov_nxt = 1'b1; pend_leak_nxt = 1'b0;
        end else if (stat.cur_leak) begin
          // hold here until the output frees, then load this leak
          if (!ov_nxt) begin
            cmd.load_out = 1'b1; cmd.out_st = RS_LEAK; cmd.out_leak = 1'b1;
            cmd.out_last = stat.walk_done; cmd.mark_rep = 1'b1;
            if (stat.walk_done) begin
              ov_nxt = 1'b1; state_nxt = S_IDLE;
            end else begin
              pend_leak_nxt = 1'b1; cmd.adv_walk = 1'b1;
            end
          end
        end else if (stat.walk_done) begin
          // close the run: flag the held leak, or send no_leak
          if (pend_leak_r) begin
            cmd.set_last = 1'b1; ov_nxt = 1'b1; pend_leak_nxt = 1'b0;
            state_nxt = S_IDLE;
          end else if (!ov_nxt) begin
            cmd.load_out = 1'b1; cmd.out_st = RS_NOLEAK; cmd.out_zero = 1'b1;
            cmd.out_last = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
          end
        end else cmd.adv_walk = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; pend_leak_r <= 1'b0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; pend_leak_r <= pend_leak_nxt;
    end
  end
endmodule
